[rtl/core/block_free_list_allocator_assert.svh]
// Assertion macros shared by the free list allocator RTL.
`ifndef BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BFLA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BFLA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/bfla_pkg.sv]
// Shared types and codes of the free list allocator.
package bfla_pkg;

   // Operation codes carried in the request word.
   typedef enum logic [1:0] {
      FN_ALLOC      = 2'd0,
      FN_FREE_ONE   = 2'd1,
      FN_FREE_CHAIN = 2'd2,
      FN_SET_LINK   = 2'd3
   } fn_type;

   // Status codes returned in the response word.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_BLOCK = 2'd1,
      ST_TOO_LONG = 2'd2
   } st_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_ALLOC_POP,
      S_FREE_TAIL,
      S_WALK,
      S_RESP
   } state_type;

   // Control strobes from the sequencer to the link memory.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

   // Response word as built by the sequencer.
   typedef struct packed {
      logic [9:0] given_block;
      st_type     status;
      logic       list_empty;
   } rsp_type;

endpackage

[rtl/core/bfla_link_ram.sv]
// Next-pointer memory: one write port and one registered read port.
module bfla_link_ram import bfla_pkg::*; #(
   parameter int NUM_BLOCKS = 1024
) (
   input  logic                          clock,
   input  ram_ctl_type                   ctl,
   input  logic [$clog2(NUM_BLOCKS)-1:0] rd_addr,
   input  logic [$clog2(NUM_BLOCKS)-1:0] wr_addr,
   input  logic [$clog2(NUM_BLOCKS):0]   wr_data,
   output logic [$clog2(NUM_BLOCKS):0]   rd_data
);

   localparam int BW = $clog2(NUM_BLOCKS);

   // Top bit of an entry marks the end of a chain; the rest is the successor.
   logic [BW:0] mem_ff [NUM_BLOCKS];
   logic [BW:0] rd_data_ff;

   // Entries hold no reset value; they are defined once written.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bfla_seq.sv]
// Sequencer and list registers: runs one operation at a time through its states.
module bfla_seq import bfla_pkg::*; #(
   parameter int NUM_BLOCKS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  fn_type                        op_func,
   input  logic [$clog2(NUM_BLOCKS)-1:0] op_blk,
   input  logic                          op_blk_none,
   input  logic [$clog2(NUM_BLOCKS)-1:0] op_nref,
   input  logic                          op_nref_none,
   input  logic                          slot_free,
   output logic                          busy,
   output logic                          load,
   output rsp_type                       rsp,
   output ram_ctl_type                   ram_ctl,
   output logic [$clog2(NUM_BLOCKS)-1:0] rd_addr,
   output logic [$clog2(NUM_BLOCKS)-1:0] wr_addr,
   output logic [$clog2(NUM_BLOCKS):0]   wr_data,
   input  logic [$clog2(NUM_BLOCKS):0]   rd_data
);

   localparam int BW = $clog2(NUM_BLOCKS);
   localparam logic [BW:0]   NONE_PTR   = {1'b1, {BW{1'b0}}};
   localparam logic [BW-1:0] STEP_LIMIT = BW'(NUM_BLOCKS - 1);

   state_type     state_ff, state_in;
   logic [BW:0]   front_ff, front_in;
   logic [BW:0]   end_ff, end_in;
   logic [BW-1:0] cur_ff, cur_in;
   logic [BW-1:0] steps_ff, steps_in;
   logic [BW-1:0] given_ff, given_in;
   st_type        status_ff, status_in;
   logic          single;
   logic          walk_last;
   logic          walk_limit;

   // The list holds one block when front and end name the same block.
   assign single = !end_ff[BW] && (end_ff[BW-1:0] == front_ff[BW-1:0]);

   // The walk ends at a block without successor or when the step budget is spent.
   assign walk_last  = rd_data[BW];
   assign walk_limit = (steps_ff == STEP_LIMIT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_RESP;
            unique case (op_func)
               FN_ALLOC: begin
                  if (!front_ff[BW] && !single) begin
                     state_in = S_ALLOC_POP;
                  end
               end
               FN_FREE_ONE: begin
                  if (!op_blk_none) begin
                     state_in = S_FREE_TAIL;
                  end
               end
               FN_FREE_CHAIN: begin
                  if (!op_blk_none) begin
                     state_in = S_WALK;
                  end
               end
               FN_SET_LINK: begin
                  state_in = S_RESP;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_ALLOC_POP: begin
            state_in = S_RESP;
         end
         S_FREE_TAIL: begin
            state_in = S_RESP;
         end
         S_WALK: begin
            if (walk_last || walk_limit) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Memory strobes and register updates for each state.
   always_comb begin
      front_in  = front_ff;
      end_in    = end_ff;
      cur_in    = cur_ff;
      steps_in  = steps_ff;
      given_in  = given_ff;
      status_in = status_ff;
      ram_ctl   = '0;
      rd_addr   = op_blk;
      wr_addr   = op_blk;
      wr_data   = NONE_PTR;
      load      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            load = 1'b0;
         end
         S_DISPATCH: begin
            given_in  = '0;
            status_in = ST_OK;
            unique case (op_func)
               FN_ALLOC: begin
                  if (front_ff[BW]) begin
                     status_in = ST_NO_BLOCK;
                  end else begin
                     given_in = front_ff[BW-1:0];
                     if (single) begin
                        // Last block leaves: both ends become empty.
                        front_in       = NONE_PTR;
                        end_in         = NONE_PTR;
                        ram_ctl.wr_en  = 1'b1;
                        wr_addr        = front_ff[BW-1:0];
                        wr_data        = NONE_PTR;
                     end else begin
                        ram_ctl.rd_en = 1'b1;
                        rd_addr       = front_ff[BW-1:0];
                     end
                  end
               end
               FN_FREE_ONE: begin
                  if (!op_blk_none) begin
                     // Append after the current end, or start a new list.
                     if (front_ff[BW]) begin
                        front_in = {1'b0, op_blk};
                     end else begin
                        ram_ctl.wr_en = 1'b1;
                        wr_addr       = end_ff[BW-1:0];
                        wr_data       = {1'b0, op_blk};
                     end
                     end_in = {1'b0, op_blk};
                  end
               end
               FN_FREE_CHAIN: begin
                  if (!op_blk_none) begin
                     ram_ctl.rd_en = 1'b1;
                     rd_addr       = op_blk;
                     cur_in        = op_blk;
                     steps_in      = '0;
                  end
               end
               FN_SET_LINK: begin
                  if (!op_blk_none) begin
                     ram_ctl.wr_en = 1'b1;
                     wr_addr       = op_blk;
                     wr_data       = op_nref_none ? NONE_PTR : {1'b0, op_nref};
                  end
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end
         S_ALLOC_POP: begin
            // The successor of the old front becomes the new front.
            front_in      = rd_data;
            ram_ctl.wr_en = 1'b1;
            wr_addr       = given_ff;
            wr_data       = NONE_PTR;
         end
         S_FREE_TAIL: begin
            ram_ctl.wr_en = 1'b1;
            wr_addr       = op_blk;
            wr_data       = NONE_PTR;
         end
         S_WALK: begin
            if (walk_last) begin
               // Tail found: splice the whole chain onto the list end.
               if (front_ff[BW]) begin
                  front_in = {1'b0, op_blk};
               end else begin
                  ram_ctl.wr_en = 1'b1;
                  wr_addr       = end_ff[BW-1:0];
                  wr_data       = {1'b0, op_blk};
               end
               end_in = {1'b0, cur_ff};
            end else if (walk_limit) begin
               status_in = ST_TOO_LONG;
            end else begin
               // Follow the link and fetch the next entry in the same cycle.
               cur_in        = rd_data[BW-1:0];
               steps_in      = steps_ff + 1'b1;
               ram_ctl.rd_en = 1'b1;
               rd_addr       = rd_data[BW-1:0];
            end
         end
         S_RESP: begin
            load = slot_free;
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   // Control registers and list ends.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= NONE_PTR;
         end_ff   <= NONE_PTR;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         end_ff   <= end_in;
      end
   end

   // Walk and result payload registers.
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      steps_ff  <= steps_in;
      given_ff  <= given_in;
      status_ff <= status_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp.given_block = 10'(given_ff);
   assign rsp.status      = status_ff;
   assign rsp.list_empty  = front_ff[BW];

endmodule

[rtl/core/block_free_list_allocator.sv]
// Top level of the linked free list block allocator.
// A taken request runs through dispatch and response; an allocate that leaves blocks
// behind or a free-one with a block adds a state, and free-chain walks its links in turn.
// One word at a time: a new request is taken only after the result is loaded into the
// output register, and output stalls hold back that load.
// Reset empties the list at once; link memory entries are undefined until written.
module block_free_list_allocator import bfla_pkg::*; #(
   parameter int NUM_BLOCKS = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [9:0] req_block,
   input  logic       req_block_is_none,
   input  logic [9:0] req_next_ref,
   input  logic       req_next_is_none,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [9:0] rsp_given_block,
   output logic [1:0] rsp_status,
   output logic       rsp_list_empty
);

`include "block_free_list_allocator_assert.svh"

   localparam int BW = $clog2(NUM_BLOCKS);

   logic          accept;
   logic          busy;
   logic          load;
   logic          slot_free;
   logic [9:0]    blk_mod;
   logic [9:0]    nref_mod;
   fn_type        op_func_ff;
   logic [BW-1:0] op_blk_ff;
   logic          op_blk_none_ff;
   logic [BW-1:0] op_nref_ff;
   logic          op_nref_none_ff;
   rsp_type       rsp_word;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;
   ram_ctl_type   ram_ctl;
   logic [BW-1:0] rd_addr;
   logic [BW-1:0] wr_addr;
   logic [BW:0]   wr_data;
   logic [BW:0]   rd_data;

   assign accept    = req_valid && !req_stall;
   assign req_stall = busy;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Reduce block numbers modulo the block count by shifted compare and subtract.
   always_comb begin
      blk_mod  = req_block;
      nref_mod = req_next_ref;
      for (int s = 9; s >= 0; s--) begin
         if ((NUM_BLOCKS << s) < 1024) begin
            if (32'(blk_mod) >= 32'(NUM_BLOCKS << s)) begin
               blk_mod = blk_mod - 10'(NUM_BLOCKS << s);
            end
            if (32'(nref_mod) >= 32'(NUM_BLOCKS << s)) begin
               nref_mod = nref_mod - 10'(NUM_BLOCKS << s);
            end
         end
      end
   end

   // Capture the request word when it is taken.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_func_ff      <= fn_type'(req_func);
         op_blk_ff       <= BW'(blk_mod);
         op_blk_none_ff  <= req_block_is_none;
         op_nref_ff      <= BW'(nref_mod);
         op_nref_none_ff <= req_next_is_none;
      end
   end

   bfla_seq #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .op_func     (op_func_ff),
      .op_blk      (op_blk_ff),
      .op_blk_none (op_blk_none_ff),
      .op_nref     (op_nref_ff),
      .op_nref_none(op_nref_none_ff),
      .slot_free   (slot_free),
      .busy        (busy),
      .load        (load),
      .rsp         (rsp_word),
      .ram_ctl     (ram_ctl),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_data     (rd_data)
   );

   bfla_link_ram #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) u_link_ram (
      .clock  (clock),
      .ctl    (ram_ctl),
      .rd_addr(rd_addr),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_data(rd_data)
   );

   // Output register: holds the response word until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_word;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_given_block = rsp_ff.given_block;
   assign rsp_status      = rsp_ff.status;
   assign rsp_list_empty  = rsp_ff.list_empty;

   // A taken request keeps the block busy in the following cycle.
   `BFLA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
                     "not busy after accept")

   // A failed allocate reports an empty list and hands out no block.
   `BFLA_ASSERT_NOW(a_no_block_empty, rsp_valid && rsp_status == ST_NO_BLOCK,
                    rsp_list_empty && rsp_given_block == 10'd0,
                    "failed allocate with list or block")

   // A chain walk that ran out of steps hands out no block.
   `BFLA_ASSERT_NOW(a_too_long_no_block, rsp_valid && rsp_status == ST_TOO_LONG,
                    rsp_given_block == 10'd0, "long chain with given block")

endmodule
